>>> src/pmm_pkg.sv
// Package for the paged memory mapper card.
// Holds the access kind codes, decode constants and address widths.
// No dependencies.
package pmm_pkg;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_CTRL  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    localparam int unsigned PAGE_COUNT = 16;
    localparam int unsigned PAGE_IDX_W = 4;
    localparam int unsigned PAGE_W     = 8;
    localparam int unsigned OFFSET_W   = 12;
    localparam int unsigned BUS_ADDR_W = 16;
    localparam int unsigned FULL_ADDR_W = PAGE_W + OFFSET_W;

    // Address decode
    localparam logic [15:0] CTRL_BLOCK_MASK = 16'hff00;
    localparam logic [15:0] CTRL_BLOCK_BASE = 16'h1e00;
    localparam logic [15:0] CTRL_SEL_MASK   = 16'h000e;
    localparam logic [15:0] CTRL_SEL_WINDOW = 16'h0000;
    localparam logic [15:0] CTRL_SEL_MAP    = 16'h0002;
    localparam logic [15:0] WIN8K_MASK      = 16'he000;
    localparam logic [15:0] WIN16K_MASK     = 16'hc000;
    localparam logic [15:0] MAPPER_BASE     = 16'h4000;
    localparam logic [15:0] LOW_MEM_BASE    = 16'h2000;
    localparam logic [15:0] HIGH_MEM_BASE_A = 16'ha000;
    localparam logic [15:0] HIGH_MEM_BASE_C = 16'hc000;

endpackage

>>> src/paged_memory_mapper_card_top.sv
// Top level of the paged memory mapper card: page registers, control bits
// and the expansion memory array. Depends on pmm_pkg.
//
//  Channel  | Valid    | Stall    | Word fields
//  ---------+----------+----------+-----------------------------------
//  input    | i_valid  | o_stall  | i_kind, i_address, i_wdata
//  output   | o_valid  | i_stall  | o_read_data, o_read_hit
//
// The result word of each access is shown on the
// next cycle; with no output stall the card takes one word per cycle.
// The expansion memory has a single port, and its read data is registered.
// Reset (i_rst_n low, synchronous) clears the page registers, map mode and
// the mapper window enable, and empties the output stage. The expansion
// memory is not cleared; its contents are undefined until written.
// While a result word waits under i_stall, o_stall holds the input side.
module paged_memory_mapper_card_top
    import pmm_pkg::*;
#(
    parameter int unsigned MEM_ADDR_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_wdata,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic        o_read_hit
);

    localparam int unsigned MEM_DEPTH = 1 << MEM_ADDR_BITS;

    // Control state
    logic [PAGE_W-1:0] r_page [PAGE_COUNT];
    logic              r_map_en;
    logic              r_win_en;

    // Output stage
    logic              r_s1_valid;
    logic              r_s1_hit;
    logic              r_s1_from_mem;
    logic [7:0]        r_s1_data;

    // Expansion memory
    logic [7:0]        r_mem [MEM_DEPTH];
    logic [7:0]        r_mem_q;

    logic                     w_accept;
    t_kind                    w_kind;
    logic                     w_in_mapper;
    logic                     w_in_mem;
    logic [PAGE_IDX_W-1:0]    w_page_idx;
    logic [PAGE_W-1:0]        w_page_val;
    logic [FULL_ADDR_W-1:0]   w_full_addr;
    logic [MEM_ADDR_BITS-1:0] w_mem_addr;
    logic                     w_mem_we;
    logic                     w_mem_re;
    logic                     w_pg_we;
    logic                     w_ctrl_hit;

    // Hold the input whenever a result word is waiting and not being taken.
    assign o_stall  = r_s1_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;
    assign w_kind   = t_kind'(i_kind);

    always_comb begin
        w_in_mapper = r_win_en && ((i_address & WIN8K_MASK) == MAPPER_BASE);
        w_in_mem    = ((i_address & WIN8K_MASK) == LOW_MEM_BASE)
                   || ((i_address & WIN8K_MASK) == HIGH_MEM_BASE_A)
                   || ((i_address & WIN16K_MASK) == HIGH_MEM_BASE_C);

        // One lookup port: the mapper window picks by bits 4:1, memory by 15:12.
        // The two windows never overlap.
        if (w_in_mapper) begin
            w_page_idx = i_address[PAGE_IDX_W:1];
        end else begin
            w_page_idx = i_address[BUS_ADDR_W-1 -: PAGE_IDX_W];
        end
        w_page_val = r_page[w_page_idx];

        if (r_map_en) begin
            w_full_addr = {w_page_val, i_address[OFFSET_W-1:0]};
        end else begin
            w_full_addr = {{(FULL_ADDR_W-BUS_ADDR_W){1'b0}}, i_address};
        end
        w_mem_addr = w_full_addr[MEM_ADDR_BITS-1:0];

        w_mem_we   = w_accept && (w_kind == KIND_WRITE) && w_in_mem;
        w_mem_re   = w_accept && (w_kind == KIND_READ) && w_in_mem;
        w_pg_we    = w_accept && (w_kind == KIND_WRITE) && w_in_mapper;
        w_ctrl_hit = w_accept && (w_kind == KIND_CTRL)
                  && ((i_address & CTRL_BLOCK_MASK) == CTRL_BLOCK_BASE);
    end

    // Page registers and control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAGE_COUNT; i++) begin
                r_page[i] <= '0;
            end
            r_map_en <= 1'b0;
            r_win_en <= 1'b0;
        end else begin
            if (w_pg_we) begin
                r_page[w_page_idx] <= i_wdata;
            end
            if (w_ctrl_hit) begin
                if ((i_address & CTRL_SEL_MASK) == CTRL_SEL_WINDOW) begin
                    r_win_en <= (i_wdata != 8'd0);
                end else if ((i_address & CTRL_SEL_MASK) == CTRL_SEL_MAP) begin
                    r_map_en <= (i_wdata != 8'd0);
                end
            end
        end
    end

    // Expansion memory: one port, registered read data. The read register
    // only moves on an accepted read, so it holds under an output stall.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= i_wdata;
        end
        if (w_mem_re) begin
            r_mem_q <= r_mem[w_mem_addr];
        end
    end

    // Output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (!i_stall) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_from_mem <= w_mem_re;
            r_s1_hit      <= (w_kind == KIND_READ) && (w_in_mem || w_in_mapper);
            if ((w_kind == KIND_READ) && w_in_mapper) begin
                r_s1_data <= w_page_val;
            end else begin
                r_s1_data <= 8'd0;
            end
        end
    end

    assign o_valid     = r_s1_valid;
    assign o_read_hit  = r_s1_hit;
    assign o_read_data = r_s1_from_mem ? r_mem_q : r_s1_data;

    // Checks
    a_no_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_read_hit) |-> (o_read_data == 8'd0))
        else $error("result without hit carries nonzero data");

    a_mem_is_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_s1_from_mem) |-> o_read_hit)
        else $error("memory read result lost its hit flag");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((w_mem_we || w_pg_we) && w_mem_re))
        else $error("read and write issued for one access");

    a_reset_ctrl: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_map_en && !r_win_en && !r_s1_valid))
        else $error("control state not cleared by reset");

endmodule
